// ===== rtl/core/amma_pkg.sv =====
// amma_pkg: shared widths and handshake structs for the accelerometer magnitude core
// no dependencies; used by the shared multiplier, the ring and the top level

package amma_pkg;

  localparam int AXIS_W    = 8;   // one signed axis sample
  localparam int MAG_W     = 8;   // magnitude and smoothed value
  localparam int SUM_W     = 16;  // sum of squares, at most 49152
  localparam int TOTAL_W   = 12;  // running ring total
  localparam int OPA_W     = 12;  // shared unit operand a
  localparam int OPB_W     = 17;  // shared unit operand b (holds the reciprocal)
  localparam int PROD_W    = OPA_W + OPB_W;
  localparam int DIV_SHIFT = 16;  // reciprocal scale, 2**16
  localparam int MAG_MAX   = 221; // floor sqrt of 3 * 128 * 128

  typedef struct packed {
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
    logic [SUM_W-1:0] lim;
  } mul_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              le;
  } mul_rsp_t;

endpackage

// ===== rtl/core/amma_mul.sv =====
// amma_mul: shared multiply and compare unit of the magnitude core
// depends on amma_pkg for the request and response structs

module amma_mul (
  input  amma_pkg::mul_req_t req,
  output amma_pkg::mul_rsp_t rsp
);

  logic [amma_pkg::PROD_W-1:0] prod;

  // product, then test against the limit (square root trial and mean correction)
  assign prod     = amma_pkg::PROD_W'(req.a) * amma_pkg::PROD_W'(req.b);
  assign rsp.prod = prod;
  assign rsp.le   = (prod <= amma_pkg::PROD_W'(req.lim));

endmodule

// ===== rtl/core/amma_ring.sv =====
// amma_ring: ring of the last WINDOW magnitudes with its write slot and running total
// depends on amma_pkg for the widths

module amma_ring #(
  parameter int WINDOW = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [amma_pkg::MAG_W-1:0]   wr_mag,
  output logic [amma_pkg::TOTAL_W-1:0] total
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic [amma_pkg::MAG_W-1:0] ring [WINDOW];
  logic [SLOT_W-1:0]          slot;
  logic [amma_pkg::MAG_W-1:0] oldest;

  assign oldest = ring[slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        ring[k] <= '0;
      end
      slot  <= '0;
      total <= '0;
    end else if (wr_en) begin
      ring[slot] <= wr_mag;
      // total stays at most WINDOW * 221, no wrap while that fits in TOTAL_W bits
      total <= total - amma_pkg::TOTAL_W'(oldest) + amma_pkg::TOTAL_W'(wr_mag);
      if (slot == SLOT_LAST) begin
        slot <= '0;
      end else begin
        slot <= slot + SLOT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/accel_magnitude_moving_average_core.sv =====
// accel_magnitude_moving_average_core: top level of the accelerometer magnitude filter
// depends on amma_pkg, amma_mul (shared multiplier) and amma_ring (magnitude ring)

// usage
//   input stream s_axis: one word per three-axis sample, signed 8-bit x, y, z
//   output stream m_axis: one word per sample, magnitude and moving-average mean
//   each sample is worked by a small sequencer around one shared multiplier:
//     squaring and summing, square root (one result bit per cycle, trial
//     squared and compared), ring update, reciprocal multiply for the mean,
//     quotient correction, then the load of the output register
//   s_axis_tready is high only while the sequencer is idle, so a new sample is
//   taken only once the last one is through the sequencer
//   a held output word stalls the sequencer in its last step until it is taken,
//   a new sample is still accepted while the last result waits
//   mean = floor(total / WINDOW) over all WINDOW ring entries, unwritten ones zero
//   reset (rst, synchronous) clears the ring, slot, total and the output valid

module accel_magnitude_moving_average_core #(
  parameter int WINDOW = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // axis_x [7:0], axis_y [15:8], axis_z [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // magnitude [7:0], smoothed [15:8]
);

  localparam int AW = amma_pkg::AXIS_W;
  localparam int MW = amma_pkg::MAG_W;

  // reciprocal of the window, estimate is exact or one low
  localparam logic [amma_pkg::OPB_W-1:0] RECIP =
    amma_pkg::OPB_W'((1 << amma_pkg::DIV_SHIFT) / WINDOW);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SQUARE = 7'b0000010,
    ST_ROOT   = 7'b0000100,
    ST_RING   = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_FIX    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  localparam logic [1:0] SQ_X    = 2'd0;
  localparam logic [1:0] SQ_Y    = 2'd1;
  localparam logic [1:0] SQ_LAST = 2'd2;

  state_t state;
  logic   out_valid;

  // datapath registers
  logic [AW-1:0]                  axis_x, axis_y, axis_z;
  logic [1:0]                     sq_cnt;
  logic [amma_pkg::SUM_W-1:0]     sum;
  logic [MW-1:0]                  root;
  logic [MW-1:0]                  root_bit;
  logic [MW-1:0]                  q_est;
  logic [MW-1:0]                  quot;
  logic [MW-1:0]                  out_mag;
  logic [MW-1:0]                  out_smooth;

  logic [AW-1:0]                  axis_sel;
  logic [AW-1:0]                  axis_mag;
  logic [MW-1:0]                  root_trial;
  logic [MW:0]                    q_plus;
  logic [amma_pkg::TOTAL_W-1:0]   total;
  amma_pkg::mul_req_t             mul_req;
  amma_pkg::mul_rsp_t             mul_rsp;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_smooth, out_mag};

  // axis under squaring and its absolute value (-128 gives 128)
  always_comb begin
    unique case (sq_cnt)
      SQ_X:    axis_sel = axis_x;
      SQ_Y:    axis_sel = axis_y;
      default: axis_sel = axis_z;
    endcase
  end

  assign axis_mag   = axis_sel[AW-1] ? (~axis_sel + AW'(1)) : axis_sel;
  assign root_trial = root | root_bit;
  assign q_plus     = {1'b0, q_est} + (MW+1)'(1);

  // operand selection for the shared unit
  always_comb begin
    mul_req = '0;
    unique case (state)
      ST_SQUARE: begin
        mul_req.a = amma_pkg::OPA_W'(axis_mag);
        mul_req.b = amma_pkg::OPB_W'(axis_mag);
      end
      ST_ROOT: begin
        mul_req.a   = amma_pkg::OPA_W'(root_trial);
        mul_req.b   = amma_pkg::OPB_W'(root_trial);
        mul_req.lim = sum;
      end
      ST_DIV: begin
        mul_req.a = total;
        mul_req.b = RECIP;
      end
      ST_FIX: begin
        mul_req.a   = amma_pkg::OPA_W'(q_plus);
        mul_req.b   = amma_pkg::OPB_W'(WINDOW);
        mul_req.lim = amma_pkg::SUM_W'(total);
      end
      default: ;
    endcase
  end

  amma_mul u_mul (
    .req (mul_req),
    .rsp (mul_rsp)
  );

  amma_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (state == ST_RING),
    .wr_mag (root),
    .total  (total)
  );

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new word loads as the old one leaves, otherwise a taken word clears valid
      if ((state == ST_DONE) && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (sq_cnt == SQ_LAST) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_bit[0]) begin
            state <= ST_RING;
          end
        end
        ST_RING: state <= ST_DIV;
        ST_DIV:  state <= ST_FIX;
        ST_FIX:  state <= ST_DONE;
        ST_DONE: begin
          // wait here while the previous word is still held
          if (!out_valid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          axis_x   <= s_axis_tdata[AW-1:0];
          axis_y   <= s_axis_tdata[2*AW-1:AW];
          axis_z   <= s_axis_tdata[3*AW-1:2*AW];
          sq_cnt   <= SQ_X;
          sum      <= '0;
          root     <= '0;
          root_bit <= {1'b1, {(MW-1){1'b0}}};
        end
      end
      ST_SQUARE: begin
        sum    <= sum + mul_rsp.prod[amma_pkg::SUM_W-1:0];
        sq_cnt <= sq_cnt + 2'd1;
      end
      ST_ROOT: begin
        // keep the trial bit when its square still fits under the sum
        if (mul_rsp.le) begin
          root <= root_trial;
        end
        root_bit <= root_bit >> 1;
      end
      ST_DIV: begin
        q_est <= mul_rsp.prod[amma_pkg::DIV_SHIFT +: MW];
      end
      ST_FIX: begin
        quot <= mul_rsp.le ? q_plus[MW-1:0] : q_est;
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_mag    <= root;
          out_smooth <= quot;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/amma_checker.sv =====
// amma_checker: port-level checks on the accelerometer magnitude core
// depends on amma_pkg; bound to accel_magnitude_moving_average_core below

module amma_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  localparam logic [7:0] MAG_LIMIT = 8'(amma_pkg::MAG_MAX);

  logic in_word;
  assign in_word = s_axis_tvalid && s_axis_tready;

  // a sample keeps the core busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_word |=> !s_axis_tready)
    else $error("core ready right after taking a sample");

  // reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // both fields stay in the magnitude range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] <= MAG_LIMIT) && (m_axis_tdata[15:8] <= MAG_LIMIT))
    else $error("result out of range");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

endmodule

bind accel_magnitude_moving_average_core amma_checker u_amma_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/accel_magnitude_moving_average_core_tb.sv =====
// accel_magnitude_moving_average_core_tb: self-checking bench for the magnitude filter
// predicts magnitude and window mean for every accepted word and checks them in order
// depends on amma_pkg and accel_magnitude_moving_average_core
`timescale 1ns / 100ps

module accel_magnitude_moving_average_core_tb;

  localparam int WINDOW_LEN  = 10;
  localparam int CLK_HALF    = 6;
  localparam int RESET_LEN   = 8;
  localparam int RANDOM_LEN  = 1900;
  localparam int DRAIN_LEN   = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_WAIT    = 19;

  typedef struct packed {
    logic [amma_pkg::MAG_W-1:0] smoothed;
    logic [amma_pkg::MAG_W-1:0] magnitude;
  } filter_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // own copy of the filter state
  logic [amma_pkg::MAG_W-1:0]   mag_ring [WINDOW_LEN];
  int unsigned                  next_slot;
  logic [amma_pkg::TOTAL_W-1:0] ring_total;

  filter_word_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int           recv_hold = 0;
  bit           send_quiet = 1'b0;
  bit           recv_quiet = 1'b0;

  accel_magnitude_moving_average_core #(
    .WINDOW(WINDOW_LEN)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int axis_abs(input logic [amma_pkg::AXIS_W-1:0] raw);
    int v;
    v = int'($signed(raw));
    return (v < 0) ? -v : v;
  endfunction

  // magnitude and mean after writing the new magnitude into the ring
  function automatic filter_word_t filter_sample(input logic [23:0] word);
    filter_word_t res;
    int           ax, ay, az, sq_sum, root;
    ax = axis_abs(word[7:0]);
    ay = axis_abs(word[15:8]);
    az = axis_abs(word[23:16]);
    sq_sum = ax * ax + ay * ay + az * az;
    root = 0;
    while ((root + 1) * (root + 1) <= sq_sum) root++;
    ring_total = ring_total - mag_ring[next_slot] + root[amma_pkg::MAG_W-1:0];
    mag_ring[next_slot] = root[amma_pkg::MAG_W-1:0];
    next_slot = (next_slot == WINDOW_LEN - 1) ? 0 : next_slot + 1;
    res.magnitude = root[amma_pkg::MAG_W-1:0];
    res.smoothed  = amma_pkg::MAG_W'(ring_total / WINDOW_LEN);
    return res;
  endfunction

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // input side monitor: every accepted word gets its prediction
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW_LEN; k++) mag_ring[k] = '0;
      next_slot  = 0;
      ring_total = '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      pending_results.push_back(filter_sample(s_axis_tdata));
    end
  end

  // output side: stall pattern driven at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      m_axis_tready <= 1'b0;
      recv_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    filter_word_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = filter_word_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.magnitude !== want.magnitude) begin
          $display("%0t: magnitude expected %0d actual %0d", $time, want.magnitude,
                   got.magnitude);
          error_count++;
        end
        if (got.smoothed !== want.smoothed) begin
          $display("%0t: smoothed expected %0d actual %0d", $time, want.smoothed,
                   got.smoothed);
          error_count++;
        end
      end
      recv_hold = draw_wait(recv_quiet);
    end
  end

  // valid stays high from one word to the next when no gap is drawn
  task automatic send_sample(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z);
    int gap;
    gap = draw_wait(send_quiet);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [7:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 8'h80;
      1: return 8'h7f;
      2: return 8'h00;
      3: return 8'(int'($urandom_range(0, 6)) - 3);
      default: return 8'($urandom);
    endcase
  endfunction

  // ring still filling: unwritten entries count as zero, extremes of each axis
  task automatic test_ring_fill();
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    send_sample(8'h00, 8'h00, 8'h00);
    send_sample(8'h80, 8'h80, 8'h80);
    send_sample(8'h7f, 8'h7f, 8'h7f);
    send_sample(8'h80, 8'h00, 8'h00);
    send_sample(8'h00, 8'h7f, 8'h00);
    send_sample(8'h00, 8'h00, 8'h81);
    send_sample(8'hff, 8'hff, 8'hff);
    send_sample(8'd3, 8'hfc, 8'd0);
    send_sample(8'd2, 8'd3, 8'hfa);
    send_sample(8'h01, 8'h00, 8'h00);
  endtask

  // slot wrap with full-scale words, then back to zero, under random idling
  task automatic test_slot_wrap();
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    repeat (WINDOW_LEN + 2) send_sample(8'h80, 8'h80, 8'h80);
    send_sample(8'h00, 8'h00, 8'h00);
    send_sample(8'h55, 8'haa, 8'h33);
    send_sample(8'hcc, 8'h0f, 8'hf0);
  endtask

  // random words, idling switched between stretches
  task automatic test_random_samples();
    for (int n = 0; n < RANDOM_LEN; n++) begin
      if (n % 64 == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
        recv_quiet = ($urandom_range(0, 3) == 0);
      end
      send_sample(pick_axis(), pick_axis(), pick_axis());
    end
  endtask

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_ring_fill();
    test_slot_wrap();
    test_random_samples();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
